@@ design/bmp24_pkg.sv @@
// shared types and constants for the 24-bit bmp stream parser
// no dependencies; used by every other design file except bmp24_byte_if
`default_nettype none

package bmp24_pkg;

  // size limits of an accepted image
  localparam int MAX_COLS = 4096;
  localparam int MAX_ROWS = 4096;

  // header layout
  localparam int HEADER_BYTES = 54;
  localparam int HDR_W        = $clog2(HEADER_BYTES);
  localparam int WIDTH_OFS    = 18;
  localparam int HEIGHT_OFS   = 22;
  localparam int DEPTH_OFS    = 28;
  localparam int GOOD_DEPTH   = 24;

  // counter widths follow the limits, output positions are fixed at 12 bits
  localparam int COL_W = $clog2(MAX_COLS + 1);
  localparam int ROW_W = $clog2(MAX_ROWS + 1);
  localparam int POS_W = 12;

  // result kinds
  typedef enum logic [1:0] {
    KIND_PIXEL     = 2'd0,
    KIND_BAD_DEPTH = 2'd1,
    KIND_TOO_LARGE = 2'd2,
    KIND_EMPTY     = 2'd3
  } kind_t;

  // position of a byte inside its pixel triple
  typedef enum logic [1:0] {
    SLOT_BLUE  = 2'd0,
    SLOT_GREEN = 2'd1,
    SLOT_RED   = 2'd2
  } slot_t;

  // command handed from the parser front to the assembler back
  typedef struct packed {
    kind_t            kind;
    slot_t            slot;
    logic [7:0]       data;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
  } cmd_t;

endpackage

`default_nettype wire

@@ design/bmp24_byte_if.sv @@
// byte input channel of the bmp parser: valid/ready plus file byte
// depends on nothing
`default_nettype none

interface bmp24_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_of_file;

  modport source (output valid, data_byte, start_of_file, input ready);
  modport sink (input valid, data_byte, start_of_file, output ready);
endinterface

`default_nettype wire

@@ design/bmp24_result_if.sv @@
// result channel of the bmp parser: valid/ready plus pixel or status word
// depends on bmp24_pkg
`default_nettype none

interface bmp24_result_if;
  logic                             valid;
  logic                             ready;
  bmp24_pkg::kind_t                 kind;
  logic [7:0]                       red;
  logic [7:0]                       green;
  logic [7:0]                       blue;
  logic [bmp24_pkg::POS_W-1:0]      pixel_row;
  logic [bmp24_pkg::POS_W-1:0]      pixel_col;
  logic                             last;

  modport source (output valid, kind, red, green, blue, pixel_row, pixel_col, last,
                  input ready);
  modport sink (input valid, kind, red, green, blue, pixel_row, pixel_col, last,
                output ready);
endinterface

`default_nettype wire

@@ design/bmp24_front.sv @@
// parser front: header counting, size and depth checks, row/column/pad tracking
// depends on bmp24_pkg and bmp24_byte_if; emits one command per pixel byte or status
`default_nettype none

module bmp24_front (
  input  wire logic            clk,
  input  wire logic            rst,
  bmp24_byte_if.sink           byte_in,
  input  wire logic            room,
  output logic                 push,
  output bmp24_pkg::cmd_t      cmd
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_HEADER,
    PH_PIXEL,
    PH_PAD
  } phase_t;

  phase_t                          phase, phase_next;
  logic [bmp24_pkg::HDR_W-1:0]     header_index, header_index_next;
  logic [31:0]                     image_width, image_width_next;
  logic [31:0]                     image_height, image_height_next;
  logic [15:0]                     pixel_depth, pixel_depth_next;
  bmp24_pkg::slot_t                byte_in_pixel, byte_in_pixel_next;
  logic [bmp24_pkg::ROW_W-1:0]     row_counter, row_counter_next;
  logic [bmp24_pkg::COL_W-1:0]     col_counter, col_counter_next;
  logic [1:0]                      pad_counter, pad_counter_next;

  logic                            take;
  logic [bmp24_pkg::HDR_W-1:0]     lane;
  logic                            row_end;
  logic                            col_end;
  logic                            final_pixel;
  logic [1:0]                      pad_dec;

  assign byte_in.ready = room;
  assign take          = byte_in.valid && room;

  // end-of-row and end-of-image detection
  assign col_end     = (32'(col_counter) + 32'd1) == image_width;
  assign row_end     = (32'(row_counter) + 32'd1) == image_height;
  assign final_pixel = row_end && col_end;

  // next state and command generation
  always_comb begin
    phase_next         = phase;
    header_index_next  = header_index;
    image_width_next   = image_width;
    image_height_next  = image_height;
    pixel_depth_next   = pixel_depth;
    byte_in_pixel_next = byte_in_pixel;
    row_counter_next   = row_counter;
    col_counter_next   = col_counter;
    pad_counter_next   = pad_counter;
    lane               = '0;
    pad_dec            = '0;
    push               = 1'b0;
    cmd                = '0;
    cmd.kind           = bmp24_pkg::KIND_PIXEL;
    cmd.slot           = bmp24_pkg::SLOT_BLUE;

    if (take) begin
      // start of file restarts the parser from header byte 0
      if (byte_in.start_of_file) begin
        phase_next         = PH_HEADER;
        header_index_next  = '0;
        image_width_next   = '0;
        image_height_next  = '0;
        pixel_depth_next   = '0;
        byte_in_pixel_next = bmp24_pkg::SLOT_BLUE;
        row_counter_next   = '0;
        col_counter_next   = '0;
        pad_counter_next   = '0;
      end

      unique case (phase_next)
        PH_HEADER: begin
          // capture little-endian fields
          if (header_index_next >= bmp24_pkg::HDR_W'(bmp24_pkg::WIDTH_OFS) &&
              header_index_next <  bmp24_pkg::HDR_W'(bmp24_pkg::WIDTH_OFS + 4)) begin
            lane = header_index_next - bmp24_pkg::HDR_W'(bmp24_pkg::WIDTH_OFS);
            image_width_next[{lane[1:0], 3'b000} +: 8] = byte_in.data_byte;
          end else if (header_index_next >= bmp24_pkg::HDR_W'(bmp24_pkg::HEIGHT_OFS) &&
                       header_index_next <  bmp24_pkg::HDR_W'(bmp24_pkg::HEIGHT_OFS + 4)) begin
            lane = header_index_next - bmp24_pkg::HDR_W'(bmp24_pkg::HEIGHT_OFS);
            image_height_next[{lane[1:0], 3'b000} +: 8] = byte_in.data_byte;
          end else if (header_index_next >= bmp24_pkg::HDR_W'(bmp24_pkg::DEPTH_OFS) &&
                       header_index_next <  bmp24_pkg::HDR_W'(bmp24_pkg::DEPTH_OFS + 2)) begin
            lane = header_index_next - bmp24_pkg::HDR_W'(bmp24_pkg::DEPTH_OFS);
            pixel_depth_next[{lane[0], 3'b000} +: 8] = byte_in.data_byte;
          end

          if (header_index_next == bmp24_pkg::HDR_W'(bmp24_pkg::HEADER_BYTES - 1)) begin
            header_index_next  = '0;
            byte_in_pixel_next = bmp24_pkg::SLOT_BLUE;
            row_counter_next   = '0;
            col_counter_next   = '0;
            phase_next         = PH_IDLE;
            cmd.last           = 1'b1;
            // depth first, then size, then empty
            priority if (pixel_depth_next != 16'(bmp24_pkg::GOOD_DEPTH)) begin
              push     = 1'b1;
              cmd.kind = bmp24_pkg::KIND_BAD_DEPTH;
            end else if (image_width_next > 32'(bmp24_pkg::MAX_COLS) ||
                         image_height_next > 32'(bmp24_pkg::MAX_ROWS)) begin
              push     = 1'b1;
              cmd.kind = bmp24_pkg::KIND_TOO_LARGE;
            end else if (image_width_next == '0 || image_height_next == '0) begin
              push     = 1'b1;
              cmd.kind = bmp24_pkg::KIND_EMPTY;
            end else begin
              phase_next = PH_PIXEL;
            end
          end else begin
            header_index_next = header_index_next + bmp24_pkg::HDR_W'(1);
          end
        end

        PH_PIXEL: begin
          // every pixel byte goes to the back, tagged with its place
          push     = 1'b1;
          cmd.slot = byte_in_pixel;
          cmd.data = byte_in.data_byte;
          cmd.row  = row_counter;
          cmd.col  = col_counter;
          cmd.last = final_pixel;
          unique case (byte_in_pixel)
            bmp24_pkg::SLOT_BLUE:  byte_in_pixel_next = bmp24_pkg::SLOT_GREEN;
            bmp24_pkg::SLOT_GREEN: byte_in_pixel_next = bmp24_pkg::SLOT_RED;
            default: begin
              byte_in_pixel_next = bmp24_pkg::SLOT_BLUE;
              priority if (final_pixel) begin
                phase_next = PH_IDLE;
              end else if (col_end) begin
                col_counter_next = '0;
                row_counter_next = row_counter + bmp24_pkg::ROW_W'(1);
                pad_counter_next = image_width[1:0];
                if (image_width[1:0] != 2'd0) begin
                  phase_next = PH_PAD;
                end
              end else begin
                col_counter_next = col_counter + bmp24_pkg::COL_W'(1);
              end
            end
          endcase
        end

        PH_PAD: begin
          // drop row padding bytes
          pad_dec          = (pad_counter != 2'd0) ? pad_counter - 2'd1 : 2'd0;
          pad_counter_next = pad_dec;
          if (pad_dec == 2'd0) begin
            phase_next = PH_PIXEL;
          end
        end

        PH_IDLE: begin
        end
      endcase
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      header_index  <= '0;
      image_width   <= '0;
      image_height  <= '0;
      pixel_depth   <= '0;
      byte_in_pixel <= bmp24_pkg::SLOT_BLUE;
      row_counter   <= '0;
      col_counter   <= '0;
      pad_counter   <= '0;
    end else begin
      phase         <= phase_next;
      header_index  <= header_index_next;
      image_width   <= image_width_next;
      image_height  <= image_height_next;
      pixel_depth   <= pixel_depth_next;
      byte_in_pixel <= byte_in_pixel_next;
      row_counter   <= row_counter_next;
      col_counter   <= col_counter_next;
      pad_counter   <= pad_counter_next;
    end
  end

endmodule

`default_nettype wire

@@ design/bmp24_queue.sv @@
// two-entry command queue between parser front and assembler back
// depends on bmp24_pkg
`default_nettype none

module bmp24_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  bmp24_pkg::cmd_t       push_cmd,
  output logic                  room,
  input  wire logic             pop,
  output logic                  avail,
  output bmp24_pkg::cmd_t       head
);

  bmp24_pkg::cmd_t entries [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      count;

  assign room  = count != 2'd2;
  assign avail = count != 2'd0;
  assign head  = entries[rd_ptr];

  // payload storage
  always_ff @(posedge clk) begin
    if (push && room) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push && room) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop && avail) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({push && room, pop && avail})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ design/bmp24_back.sv @@
// assembler back: gathers b,g,r bytes into pixels and drives the result register
// depends on bmp24_pkg and bmp24_result_if
`default_nettype none

module bmp24_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            avail,
  input  bmp24_pkg::cmd_t      head,
  output logic                 pop,
  bmp24_result_if.source       result_out
);

  logic [15:0] held_blue_green;
  logic        out_valid;
  logic        is_result;
  logic        can_load;
  logic        is_pixel;

  assign is_pixel  = head.kind == bmp24_pkg::KIND_PIXEL;
  assign is_result = !is_pixel || head.slot == bmp24_pkg::SLOT_RED;
  assign can_load  = !out_valid || result_out.ready;
  assign pop       = avail && (!is_result || can_load);

  assign result_out.valid = out_valid;

  // blue and green holding register
  always_ff @(posedge clk) begin
    if (pop && is_pixel) begin
      unique case (head.slot)
        bmp24_pkg::SLOT_BLUE:  held_blue_green[7:0]  <= head.data;
        bmp24_pkg::SLOT_GREEN: held_blue_green[15:8] <= head.data;
        default:               held_blue_green       <= held_blue_green;
      endcase
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (pop && is_result) begin
      result_out.kind      <= head.kind;
      result_out.red       <= is_pixel ? head.data : 8'd0;
      result_out.green     <= is_pixel ? held_blue_green[15:8] : 8'd0;
      result_out.blue      <= is_pixel ? held_blue_green[7:0] : 8'd0;
      result_out.pixel_row <= is_pixel ? bmp24_pkg::POS_W'(head.row) : '0;
      result_out.pixel_col <= is_pixel ? bmp24_pkg::POS_W'(head.col) : '0;
      result_out.last      <= head.last;
    end
  end

  // output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && is_result) begin
      out_valid <= 1'b1;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

@@ design/bmp24_stream_pixel_parser_top.sv @@
// 24-bit bmp stream parser: one file byte per word in, pixel or status word out.
// throughput: one byte per cycle sustained while result_out.ready is high; the front
// parser and the back assembler each update once per cycle, joined by a two-entry
// command queue. a byte that completes a result is written to the queue at the edge
// that accepts it and is then loaded from the queue head into the result register.
// reset: synchronous rst empties queue and output; parser idles until start_of_file.
`default_nettype none

module bmp24_stream_pixel_parser_top (
  input  wire logic       clk,
  input  wire logic       rst,
  bmp24_byte_if.sink      byte_in,
  bmp24_result_if.source  result_out
);

  bmp24_pkg::cmd_t front_cmd;
  bmp24_pkg::cmd_t head;
  logic            push;
  logic            room;
  logic            pop;
  logic            avail;

  // header and position tracking
  bmp24_front u_front (
    .clk     (clk),
    .rst     (rst),
    .byte_in (byte_in),
    .room    (room),
    .push    (push),
    .cmd     (front_cmd)
  );

  // decoupling queue
  bmp24_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (front_cmd),
    .room     (room),
    .pop      (pop),
    .avail    (avail),
    .head     (head)
  );

  // pixel assembly and result register
  bmp24_back u_back (
    .clk        (clk),
    .rst        (rst),
    .avail      (avail),
    .head       (head),
    .pop        (pop),
    .result_out (result_out)
  );

endmodule

`default_nettype wire
